>>> rtl/core/rsvm_pkg.sv
// ----------------------------------------------------------------------------
// rsvm_pkg
// Shared types, widths and the multiply sequence of the running sum and
// variance merge block.
// ----------------------------------------------------------------------------
package rsvm_pkg;

    localparam int RSVM_NUM_TERMS = 64;

    // widths of the merge arithmetic
    localparam int PROD_W = 96;   // m*|S| and n*|s|
    localparam int D_W    = 97;   // |m*S - n*s|
    localparam int DEN_W  = 97;   // n*m*(n+m)
    localparam int ACC_W  = 194;  // d*d
    localparam int FRAC_W = 24;
    localparam int VAR_W  = 63;

    localparam logic [VAR_W-1:0] VAR_MAX   = {VAR_W{1'b1}};
    localparam logic [47:0]      STEP_MAX  = {48{1'b1}};
    localparam logic [31:0]      COUNT_MAX = {32{1'b1}};

    localparam logic [4:0] OP_A_LO      = 5'd0;
    localparam logic [4:0] OP_A_HI      = 5'd1;
    localparam logic [4:0] OP_B_LO      = 5'd2;
    localparam logic [4:0] OP_B_HI      = 5'd3;
    localparam logic [4:0] OP_P         = 5'd4;
    localparam logic [4:0] OP_DEN_FIRST = 5'd5;
    localparam logic [4:0] OP_DEN_HI_N  = 5'd6;
    localparam logic [4:0] OP_DEN_LO_M  = 5'd7;
    localparam logic [4:0] OP_DEN_LAST  = 5'd8;
    localparam logic [4:0] OP_SQ_FIRST  = 5'd9;
    localparam logic [4:0] OP_LAST      = 5'd24;

    typedef struct packed {
        logic        [5:0]  term_index;
        logic signed [63:0] term_value;
        logic signed [63:0] term_sum;
        logic        [62:0] term_var;
        logic        [31:0] frame_samples;
        logic        [47:0] frame_steps;
        logic        [47:0] output_step;
        logic               last_term;
        logic               restart_after;
    } in_t;

    typedef struct packed {
        logic        [5:0]  out_index;
        logic signed [63:0] run_sum;
        logic        [62:0] run_var;
        logic        [47:0] run_steps_out;
        logic        [31:0] run_count_out;
        logic               run_broken;
        logic               out_last;
    } out_t;

    typedef enum logic [2:0] {
        SRC_M,
        SRC_N,
        SRC_SMAG,
        SRC_XMAG,
        SRC_P,
        SRC_D
    } src_t;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_A,
        DST_B,
        DST_P,
        DST_DEN,
        DST_SQ
    } dest_t;

    typedef struct packed {
        src_t       a_src;
        logic [1:0] a_limb;
        src_t       b_src;
        logic [1:0] b_limb;
        logic [2:0] shift;
        logic       first;
        logic       last;
        logic       barrier;
        dest_t      dest;
    } op_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] a;
        logic [31:0] b;
        logic [2:0]  shift;
        logic        first;
        logic        last;
        dest_t       dest;
    } mac_req_t;

    typedef struct packed {
        logic  done;
        dest_t dest;
    } mac_rsp_t;

    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] sq;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [VAR_W-1:0] quot;
    } div_rsp_t;

    // partial products of one merge: A = m*|S|, B = n*|s|, P = n*m,
    // DEN = P*n + P*m, SQ = d*d over four 32-bit limbs of d
    function automatic op_t op_decode(input logic [4:0] op);
        op_t        r;
        logic [3:0] k;
        r.a_src   = SRC_M;
        r.a_limb  = 2'd0;
        r.b_src   = SRC_M;
        r.b_limb  = 2'd0;
        r.shift   = 3'd0;
        r.first   = 1'b0;
        r.last    = 1'b0;
        r.barrier = 1'b0;
        r.dest    = DST_NONE;
        k         = 4'(op - OP_SQ_FIRST);
        unique case (op)
            OP_A_LO:
            begin
                r.b_src = SRC_SMAG;
                r.first = 1'b1;
            end
            OP_A_HI:
            begin
                r.b_src  = SRC_SMAG;
                r.b_limb = 2'd1;
                r.shift  = 3'd1;
                r.last   = 1'b1;
                r.dest   = DST_A;
            end
            OP_B_LO:
            begin
                r.a_src = SRC_N;
                r.b_src = SRC_XMAG;
                r.first = 1'b1;
            end
            OP_B_HI:
            begin
                r.a_src  = SRC_N;
                r.b_src  = SRC_XMAG;
                r.b_limb = 2'd1;
                r.shift  = 3'd1;
                r.last   = 1'b1;
                r.dest   = DST_B;
            end
            OP_P:
            begin
                r.a_src = SRC_N;
                r.first = 1'b1;
                r.last  = 1'b1;
                r.dest  = DST_P;
            end
            OP_DEN_FIRST:
            begin
                r.a_src   = SRC_P;
                r.b_src   = SRC_N;
                r.first   = 1'b1;
                r.barrier = 1'b1;
            end
            OP_DEN_HI_N:
            begin
                r.a_src  = SRC_P;
                r.a_limb = 2'd1;
                r.b_src  = SRC_N;
                r.shift  = 3'd1;
            end
            OP_DEN_LO_M:
            begin
                r.a_src = SRC_P;
            end
            OP_DEN_LAST:
            begin
                r.a_src  = SRC_P;
                r.a_limb = 2'd1;
                r.shift  = 3'd1;
                r.last   = 1'b1;
                r.dest   = DST_DEN;
            end
            default:
            begin
                r.a_src   = SRC_D;
                r.a_limb  = k[3:2];
                r.b_src   = SRC_D;
                r.b_limb  = k[1:0];
                r.shift   = {1'b0, k[3:2]} + {1'b0, k[1:0]};
                r.first   = (op == OP_SQ_FIRST);
                r.barrier = (op == OP_SQ_FIRST);
                r.last    = (op == OP_LAST);
                r.dest    = (op == OP_LAST) ? DST_SQ : DST_NONE;
            end
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/rsvm_mac.sv
// ----------------------------------------------------------------------------
// rsvm_mac
// Shared 32x32 multiplier with a registered product and a shifting
// accumulator; one partial product enters per cycle.
// ----------------------------------------------------------------------------
module rsvm_mac
    import rsvm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  mac_req_t         req,
    output logic [ACC_W-1:0] acc,
    output mac_rsp_t         rsp,
    output logic             busy
);

    logic [63:0]      prod_reg;
    logic [2:0]       shift_reg;
    logic             first_reg;
    logic             last_reg;
    dest_t            dest_reg;
    logic             pend_reg;
    logic [ACC_W-1:0] acc_reg;
    logic             done_reg;
    dest_t            done_dest_reg;
    logic [255:0]     shifted;
    logic [ACC_W-1:0] acc_next;

    always_comb
    begin
        shifted  = 256'(prod_reg) << {shift_reg, 5'd0};
        acc_next = (first_reg ? '0 : acc_reg) + shifted[ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            done_reg      <= 1'b0;
            done_dest_reg <= DST_NONE;
        end
        else
        begin
            pend_reg      <= req.valid;
            done_reg      <= pend_reg && last_reg;
            done_dest_reg <= dest_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            prod_reg  <= req.a * req.b;
            shift_reg <= req.shift;
            first_reg <= req.first;
            last_reg  <= req.last;
            dest_reg  <= req.dest;
        end
        if (pend_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc      = acc_reg;
    assign rsp.done = done_reg;
    assign rsp.dest = done_dest_reg;
    assign busy     = pend_reg | done_reg;

endmodule

>>> rtl/core/rsvm_div.sv
// ----------------------------------------------------------------------------
// rsvm_div
// Restoring divider, one quotient bit per cycle: floor(sq / 2^24 / den),
// saturated to 63 bits, zero for a zero divisor.
// ----------------------------------------------------------------------------
module rsvm_div
    import rsvm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             run_reg;
    logic             done_reg;
    logic [5:0]       cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [VAR_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic             too_big;

    always_comb
    begin
        trial   = {rem_reg, quo_reg[VAR_W-1]};
        diff    = trial - {1'b0, den_reg};
        ge      = (trial >= {1'b0, den_reg});
        too_big = (req.sq[ACC_W-1:FRAC_W+VAR_W] >= 107'(req.den));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                if (req.den == '0 || too_big)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    run_reg <= 1'b1;
                    cnt_reg <= 6'(VAR_W - 1);
                end
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            den_reg <= req.den;
            rem_reg <= req.sq[FRAC_W+VAR_W+DEN_W-1:FRAC_W+VAR_W];
            if (req.den == '0)
            begin
                quo_reg <= '0;
            end
            else if (too_big)
            begin
                quo_reg <= VAR_MAX;
            end
            else
            begin
                quo_reg <= req.sq[FRAC_W+VAR_W-1:FRAC_W];
            end
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[VAR_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

>>> rtl/core/running_sum_variance_merge_core.sv
// ----------------------------------------------------------------------------
// running_sum_variance_merge_core
// Per-term running sum and sum of squared deviations over energy frames.
// ----------------------------------------------------------------------------
// Input channel in_valid / in_stall / in_data carries one term of one frame.
// Output channel out_valid / out_stall / out_data returns one result for
// every request, in order.
// The block takes one request at a time: in_stall is high from the cycle
// after a request is taken until its result is moved to the output register.
// A request that seeds or breaks the run goes from the lookup straight to
// the result. A merging request first runs 25 partial products through the
// one shared 32x32 multiplier (with two short waits on earlier products),
// then 63 iterations of the restoring divider, one quotient bit per cycle.
// The result waits in the output register while out_stall is high; the next
// request may be taken meanwhile, and its result is held until the output
// register frees.
// Reset clears the run counters and the previous step; the term stores have
// no reset and are filled as terms are seeded.
// ----------------------------------------------------------------------------
module running_sum_variance_merge_core
    import rsvm_pkg::*;
#(
    parameter int NUM_TERMS = RSVM_NUM_TERMS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    localparam int AW = (NUM_TERMS > 1) ? $clog2(NUM_TERMS) : 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOOK  = 6'b000010,
        S_MUL   = 6'b000100,
        S_DRAIN = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [63:0]      sum_mem [NUM_TERMS];
    logic [VAR_W-1:0] var_mem [NUM_TERMS];

    in_t              item_reg;
    logic             inrange_reg;
    logic [63:0]      rd_sum_reg;
    logic [VAR_W-1:0] rd_var_reg;
    logic [47:0]      prev_step_reg;
    logic [47:0]      run_steps_reg;
    logic [31:0]      run_count_reg;
    logic [4:0]       op_reg;
    logic [PROD_W-1:0] a_reg;
    logic [PROD_W-1:0] b_reg;
    logic [63:0]      p_reg;
    logic [DEN_W-1:0] den_reg;
    logic [ACC_W-1:0] sq_reg;
    logic [D_W-1:0]   d_reg;
    logic [VAR_W-1:0] extra_reg;
    logic             out_valid_reg;
    out_t             out_data_reg;

    logic             accept;
    logic             load_out;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic [31:0]      m_val;
    logic             single;
    logic [63:0]      s_eff;
    logic [VAR_W-1:0] fvar_eff;
    logic [63:0]      old_sum;
    logic [VAR_W-1:0] old_var;
    logic [63:0]      smag;
    logic [63:0]      xmag;
    logic             sign_diff;
    logic             seed;
    logic             contig;
    logic             merge;
    logic [63:0]      sum_add;
    logic [63:0]      sum_sat;
    logic [63:0]      var1;
    logic [VAR_W-1:0] var1_sat;
    logic [63:0]      var2;
    logic [VAR_W-1:0] var2_sat;
    logic [48:0]      steps_add;
    logic [32:0]      count_add;
    logic [63:0]      ns;
    logic [VAR_W-1:0] nv;
    logic [47:0]      nsteps;
    logic [31:0]      ncount;
    logic             broken;
    logic             wr_en;
    out_t             result;

    op_t              cur_op;
    logic [127:0]     cand_a;
    logic [127:0]     cand_b;
    mac_req_t         mac_req;
    mac_rsp_t         mac_rsp;
    logic [ACC_W-1:0] mac_acc;
    logic             mac_busy;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    function automatic logic [127:0] src_word(
        input src_t        src,
        input logic [31:0] mv,
        input logic [31:0] nv_in,
        input logic [63:0] sm,
        input logic [63:0] xm,
        input logic [63:0] pv,
        input logic [D_W-1:0] dv
    );
        logic [127:0] w;
        case (src)
            SRC_M:    w = 128'(mv);
            SRC_N:    w = 128'(nv_in);
            SRC_SMAG: w = 128'(sm);
            SRC_XMAG: w = 128'(xm);
            SRC_P:    w = 128'(pv);
            SRC_D:    w = 128'(dv);
            default:  w = '0;
        endcase
        return w;
    endfunction

    // ---------------- request decode ----------------
    always_comb
    begin
        accept   = in_valid && !in_stall;
        load_out = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
        rd_addr  = AW'(in_data.term_index);
        wr_addr  = AW'(item_reg.term_index);

        m_val     = (item_reg.frame_samples == '0) ? 32'd1 : item_reg.frame_samples;
        single    = (m_val == 32'd1);
        s_eff     = single ? item_reg.term_value : item_reg.term_sum;
        fvar_eff  = single ? '0 : item_reg.term_var;
        old_sum   = inrange_reg ? rd_sum_reg : '0;
        old_var   = inrange_reg ? rd_var_reg : '0;
        smag      = old_sum[63] ? (~old_sum + 64'd1) : old_sum;
        xmag      = s_eff[63] ? (~s_eff + 64'd1) : s_eff;
        sign_diff = old_sum[63] ^ s_eff[63];

        seed   = (run_steps_reg == '0);
        contig = (50'(item_reg.output_step) + 50'(run_count_reg))
              == (50'(prev_step_reg) + 50'(run_steps_reg) + 50'(item_reg.frame_steps));
        merge  = !seed && contig;
    end

    // ---------------- result ----------------
    always_comb
    begin
        sum_add = old_sum + s_eff;
        if (old_sum[63] == s_eff[63] && sum_add[63] != old_sum[63])
        begin
            sum_sat = old_sum[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
        else
        begin
            sum_sat = sum_add;
        end
        var1      = {1'b0, old_var} + {1'b0, fvar_eff};
        var1_sat  = var1[63] ? VAR_MAX : var1[VAR_W-1:0];
        var2      = {1'b0, var1_sat} + {1'b0, extra_reg};
        var2_sat  = var2[63] ? VAR_MAX : var2[VAR_W-1:0];
        steps_add = {1'b0, run_steps_reg} + {1'b0, item_reg.frame_steps};
        count_add = {1'b0, run_count_reg} + {1'b0, m_val};

        broken = 1'b0;
        wr_en  = 1'b0;
        ns     = '0;
        nv     = '0;
        nsteps = '0;
        ncount = '0;
        if (seed)
        begin
            ns     = s_eff;
            nv     = fvar_eff;
            nsteps = item_reg.frame_steps;
            ncount = m_val;
            wr_en  = 1'b1;
        end
        else if (contig)
        begin
            ns     = sum_sat;
            nv     = var2_sat;
            nsteps = steps_add[48] ? STEP_MAX : steps_add[47:0];
            ncount = count_add[32] ? COUNT_MAX : count_add[31:0];
            wr_en  = 1'b1;
        end
        else
        begin
            broken = (item_reg.frame_samples != '0);
        end

        result.out_index     = item_reg.term_index;
        result.run_sum       = ns;
        result.run_var       = nv;
        result.run_steps_out = nsteps;
        result.run_count_out = ncount;
        result.run_broken    = broken;
        result.out_last      = item_reg.last_term;
    end

    // ---------------- multiply sequence ----------------
    always_comb
    begin
        cur_op = op_decode(op_reg);
        cand_a = src_word(cur_op.a_src, m_val, run_count_reg, smag, xmag, p_reg, d_reg);
        cand_b = src_word(cur_op.b_src, m_val, run_count_reg, smag, xmag, p_reg, d_reg);

        mac_req.valid = (state_reg == S_MUL) && !(cur_op.barrier && mac_busy);
        mac_req.a     = cand_a[{cur_op.a_limb, 5'd0} +: 32];
        mac_req.b     = cand_b[{cur_op.b_limb, 5'd0} +: 32];
        mac_req.shift = cur_op.shift;
        mac_req.first = cur_op.first;
        mac_req.last  = cur_op.last;
        mac_req.dest  = cur_op.dest;

        div_req.start = (state_reg == S_DRAIN) && !mac_busy;
        div_req.sq    = sq_reg;
        div_req.den   = den_reg;
    end

    rsvm_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .acc   (mac_acc),
        .rsp   (mac_rsp),
        .busy  (mac_busy)
    );

    rsvm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = merge ? S_MUL : S_DONE;
            end
            S_MUL:
            begin
                if (mac_req.valid && op_reg == OP_LAST)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!mac_busy)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= '0;
            out_valid_reg <= 1'b0;
            prev_step_reg <= '0;
            run_steps_reg <= '0;
            run_count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_LOOK)
            begin
                op_reg <= '0;
            end
            else if (mac_req.valid)
            begin
                op_reg <= op_reg + 5'd1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            // run counters commit on the last term of a frame
            if (load_out && item_reg.last_term)
            begin
                prev_step_reg <= item_reg.output_step;
                run_steps_reg <= item_reg.restart_after ? '0 : nsteps;
                run_count_reg <= item_reg.restart_after ? '0 : ncount;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg    <= in_data;
            inrange_reg <= (int'(in_data.term_index) < NUM_TERMS);
            rd_sum_reg  <= sum_mem[rd_addr];
            rd_var_reg  <= var_mem[rd_addr];
        end
        if (load_out && wr_en && inrange_reg)
        begin
            sum_mem[wr_addr] <= ns;
            var_mem[wr_addr] <= nv;
        end
        if (load_out)
        begin
            out_data_reg <= result;
        end
        if (state_reg == S_LOOK)
        begin
            extra_reg <= '0;
        end
        else if (state_reg == S_DIV && div_rsp.done)
        begin
            extra_reg <= div_rsp.quot;
        end
        if (mac_rsp.done)
        begin
            unique case (mac_rsp.dest)
                DST_A:   a_reg   <= mac_acc[PROD_W-1:0];
                DST_B:   b_reg   <= mac_acc[PROD_W-1:0];
                DST_P:   p_reg   <= mac_acc[63:0];
                DST_DEN: den_reg <= mac_acc[DEN_W-1:0];
                DST_SQ:  sq_reg  <= mac_acc;
                default: ;
            endcase
        end
        // |m*S - n*s| from the two magnitudes and the sign relation
        if (sign_diff)
        begin
            d_reg <= {1'b0, a_reg} + {1'b0, b_reg};
        end
        else if (a_reg >= b_reg)
        begin
            d_reg <= {1'b0, a_reg - b_reg};
        end
        else
        begin
            d_reg <= {1'b0, b_reg - a_reg};
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/core/rsvm_checker.sv
// ----------------------------------------------------------------------------
// rsvm_checker
// Port-level checks of the running sum and variance merge block.
// ----------------------------------------------------------------------------
module rsvm_checker
    import rsvm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input out_t out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // one request at a time
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while busy");

    // a new result only comes out of a busy block
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without work");

    // a broken run reports cleared sums and counts
    a_break_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.run_broken |->
            out_data.run_sum == '0 && out_data.run_var == '0 &&
            out_data.run_count_out == '0 && out_data.run_steps_out == '0)
        else $error("broken run with nonzero fields");

endmodule

bind running_sum_variance_merge_core rsvm_checker u_rsvm_checker (.*);
